FILE: sv/ps2_mouse_packet_decoder_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef PS2_MOUSE_PACKET_DECODER_CORE_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMPD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: sv/pmpd_pkg.sv
package pmpd_pkg;

  localparam int CoordWidthDef = 12;
  localparam int CfgW          = 12;
  localparam int CfgIdxW       = 2;
  localparam int CursorSize    = 16;
  localparam int TaskbarLines  = 28;
  localparam int WidthReset    = 320;
  localparam int HeightReset   = 200;

  localparam logic [7:0] AckByte = 8'hFA;
  localparam logic [7:0] HdrMask = 8'hC8;
  localparam logic [7:0] HdrSync = 8'h08;
  localparam logic [7:0] BtnMask = 8'h07;
  localparam int         XSignBit = 4;
  localparam int         YSignBit = 5;

  typedef enum logic [CfgIdxW-1:0] {
    RegScreenWidth  = 2'd0,
    RegScreenHeight = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic              pkt;
    logic [2:0]        btn;
    logic signed [8:0] dx;
    logic signed [9:0] dy;
  } cmd_t;

endpackage

FILE: sv/pmpd_front.sv
module pmpd_front import pmpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    PhAck,
    PhHeader,
    PhX,
    PhY
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] header_q, header_d;
  logic [7:0] x_q, x_d;
  logic       accept;
  logic signed [9:0] dy_raw;

  assign accept = byte_valid_i && !q_full_i;
  assign push_o = accept;
  assign dy_raw = {{2{header_q[YSignBit]}}, byte_i};

  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    x_d      = x_q;
    cmd_o    = '0;
    case (phase_q)
      PhAck: begin
        if (byte_i == AckByte) phase_d = PhHeader;
      end
      PhHeader: begin
        if ((byte_i & HdrMask) == HdrSync) begin
          header_d = byte_i;
          phase_d  = PhX;
        end
      end
      PhX: begin
        x_d     = byte_i;
        phase_d = PhY;
      end
      PhY: begin
        phase_d   = PhHeader;
        cmd_o.pkt = 1'b1;
        cmd_o.btn = 3'(header_q & BtnMask);
        cmd_o.dx  = {header_q[XSignBit], x_q};
        cmd_o.dy  = -dy_raw;
      end
      default: phase_d = PhAck;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhAck;
      header_q <= '0;
      x_q      <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      header_q <= header_d;
      x_q      <= x_d;
    end
  end

endmodule

FILE: sv/pmpd_queue.sv
module pmpd_queue import pmpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: sv/pmpd_back.sv
module pmpd_back import pmpd_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                pop_o,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_done_o,
  output logic [2:0]          out_btn_o,
  output logic signed [8:0]   out_dx_o,
  output logic signed [9:0]   out_dy_o,
  output logic [11:0]         out_col_o,
  output logic [11:0]         out_row_o
);

  localparam int CW = COORD_WIDTH;
  localparam int VW = COORD_WIDTH + 2;
  localparam logic [CW-1:0] ColReset = CW'((WidthReset - CursorSize) / 2);
  localparam logic [CW-1:0] RowReset = CW'((HeightReset - TaskbarLines - CursorSize) / 2);
  localparam logic [CW-1:0] WidthRst  = CW'(WidthReset);
  localparam logic [CW-1:0] HeightRst = CW'(HeightReset);

  function automatic logic [CW-1:0] clamp(input logic [CW-1:0] pos,
                                          input logic signed [9:0] delta,
                                          input logic [CW-1:0] size);
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] lim;
    v   = signed'({2'b00, pos}) + signed'({{(VW-10){delta[9]}}, delta});
    lim = signed'({2'b00, size}) - signed'(VW'(CursorSize));
    if (lim < 0) lim = '0;
    if (v < 0)   v = '0;
    if (v > lim) v = lim;
    return v[CW-1:0];
  endfunction

  logic [CW-1:0]      width_q, height_q;
  logic [CW-1:0]      col_q, row_q, col_d, row_d;
  logic [CW+CfgW-1:0] cfg_wide;
  logic [CW+11:0]     col_wide, row_wide;
  logic               valid_q;

  assign pop_o    = cmd_valid_i && (!valid_q || out_ready_i);
  assign cfg_wide = {{CW{1'b0}}, cfg_data_i};
  assign out_valid_o = valid_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.pkt) begin
      col_d = clamp(col_q, {cmd_i.dx[8], cmd_i.dx}, width_q);
      row_d = clamp(row_q, cmd_i.dy, height_q);
    end
  end

  assign col_wide = {12'b0, col_d};
  assign row_wide = {12'b0, row_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      col_q    <= ColReset;
      row_q    <= RowReset;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (reg_idx_e'(cfg_index_i))
          RegScreenWidth:  width_q  <= cfg_wide[CW-1:0];
          RegScreenHeight: height_q <= cfg_wide[CW-1:0];
          default: ;
        endcase
      end
      if (pop_o) begin
        col_q   <= col_d;
        row_q   <= row_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_done_o <= cmd_i.pkt;
      out_btn_o  <= cmd_i.btn;
      out_dx_o   <= cmd_i.dx;
      out_dy_o   <= cmd_i.dy;
      out_col_o  <= col_wide[11:0];
      out_row_o  <= row_wide[11:0];
    end
  end

endmodule

FILE: sv/ps2_mouse_packet_decoder_core.sv
// Path: each accepted byte is written into the command queue; the back end pops it and registers the result word.
// Throughput: one byte per cycle while the queue is not full; the two-entry command
// queue decouples the byte framer from the cursor update and output register.
// Reset (async, active low): framer waits for the acknowledge, screen is
// 320x200, cursor at column 152, row 78, queue and output empty.
module ps2_mouse_packet_decoder_core import pmpd_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [47:0]        m_axis_tdata,   // buttons, delta_x, delta_y, cursor_x, cursor_y
  output logic               m_axis_tlast,   // packet_done
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cmd_t              push_cmd, pop_cmd;
  logic              push, pop, q_full, q_valid;
  logic              done;
  logic [2:0]        btn;
  logic signed [8:0] dx;
  logic signed [9:0] dy;
  logic [11:0]       col, row;

  assign s_axis_tready = !q_full;
  assign cfg_ready_o   = 1'b1;

  pmpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  pmpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_cmd)
  );

  pmpd_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_done_o  (done),
    .out_btn_o   (btn),
    .out_dx_o    (dx),
    .out_dy_o    (dy),
    .out_col_o   (col),
    .out_row_o   (row)
  );

  assign m_axis_tlast = done;
  assign m_axis_tdata = {2'b00, row, col, dy, dx, btn};

endmodule

FILE: sv/pmpd_checker.sv
`include "ps2_mouse_packet_decoder_core_macros.svh"

module pmpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `PMPD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `PMPD_ASSERT_IMP(a_idle_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[21:0] == 22'd0)
  `PMPD_ASSERT_IMP(a_stall_src, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid)
  `PMPD_ASSERT_IMP(a_dy_range, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tdata[21:12] != 10'h300)

endmodule

bind ps2_mouse_packet_decoder_core pmpd_checker u_pmpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
